// ----- rtl/psa_pkg.sv -----
// Shared types, codes and constants of the pool slot allocator.
// No dependencies; every other file of the block imports this package.
package psa_pkg;

  // Default number of pool slots.
  localparam int POOL_SIZE_DEF = 16;

  // Widths of the external fields.
  localparam int CFG_W  = 5;
  localparam int SLOT_W = 4;

  // Reset value of the slots-in-use register.
  localparam logic [CFG_W-1:0] SLOTS_RESET = 5'd16;

  // Codes of the action field.
  localparam logic ACT_SPAWN   = 1'b0;
  localparam logic ACT_DESPAWN = 1'b1;

  // Broadcast command to the cells of the spawn-order chain.
  typedef struct packed {
    logic append;  // write a fresh grant into the first empty cell
    logic remove;  // drop the entry equal to the despawn target
    logic rotate;  // move the head entry to the tail
  } ord_cmd_t;

  // Broadcast command to the slot cells.
  typedef struct packed {
    logic spawn;    // a spawn request is being served
    logic despawn;  // a despawn event with an in-range index
    logic recycle;  // the head entry is being reissued
  } slot_cmd_t;

endpackage

// ----- rtl/psa_slot_cell.sv -----
// One pool slot: holds its active bit and forms one link of the free-slot search chain.
// Depends on psa_pkg.
module psa_slot_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  psa_pkg::slot_cmd_t  cmd,
  input  logic                eligible,
  input  logic [IDX_W-1:0]    target,
  input  logic [IDX_W-1:0]    recycle_slot,
  input  logic                take_in,
  input  logic [IDX_W-1:0]    idx_in,
  output logic                take_out,
  output logic [IDX_W-1:0]    idx_out,
  output logic                active
);
  import psa_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic free;
  logic hit;
  logic active_next;

  // The lowest free eligible slot claims the request; later cells pass it on.
  assign free     = eligible && !active;
  assign hit      = cmd.spawn && !take_in && free;
  assign take_out = take_in || free;
  assign idx_out  = (!take_in && free) ? MY_IDX : idx_in;

  // Set on a fresh grant or a recycle of this slot, cleared on its despawn.
  // A recycle always comes with a spawn; a despawn coincides with neither, and most cycles carry none.
  always_comb begin
    active_next = active;
    if (hit) begin
      active_next = 1'b1;
    end else if (cmd.recycle && recycle_slot == MY_IDX) begin
      active_next = 1'b1;
    end else if (cmd.despawn && target == MY_IDX) begin
      active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else begin
      active <= active_next;
    end
  end

endmodule

// ----- rtl/psa_order_cell.sv -----
// One entry of the spawn-order list, oldest at cell zero; entries move toward
// the head on removal and rotation. Depends on psa_pkg.
module psa_order_cell #(
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  psa_pkg::ord_cmd_t  cmd,
  input  logic [IDX_W-1:0]   new_value,
  input  logic [IDX_W-1:0]   target,
  input  logic [IDX_W-1:0]   head_value,
  input  logic               valid_left,
  input  logic               match_in,
  input  logic               valid_right,
  input  logic [IDX_W-1:0]   value_right,
  output logic               match_out,
  output logic               valid,
  output logic [IDX_W-1:0]   value
);
  import psa_pkg::*;

  logic             valid_next;
  logic [IDX_W-1:0] value_next;

  // A match here or in any cell nearer the head closes the gap from the right.
  assign match_out = match_in || (cmd.remove && valid && value == target);

  // The list commands never coincide, and most cycles carry none of them.
  always_comb begin
    valid_next = valid;
    value_next = value;
    if (cmd.remove) begin
      if (match_out) begin
        valid_next = valid_right;
        value_next = value_right;
      end
    end else if (cmd.append) begin
      // Only the first empty cell takes the new entry.
      if (!valid && valid_left) begin
        valid_next = 1'b1;
        value_next = new_value;
      end
    end else if (cmd.rotate) begin
      // Shift toward the head; the last filled cell receives the old head.
      if (valid_right) begin
        value_next = value_right;
      end else if (valid) begin
        value_next = head_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Entry values carry no reset; only filled cells are ever read.
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- rtl/pool_slot_allocator_fifo_recycle_unit.sv -----
// Top level of the pool slot allocator with oldest-first recycling.
// Depends on psa_pkg, psa_slot_cell and psa_order_cell.
//
// Usage:
//   Command channel: a word (action, slot_index) is taken at a rising edge with
//   start high and busy low. busy stays low, so a word may be issued in every
//   cycle. A spawn request (action 0) grants the lowest inactive slot below
//   slots_in_use, or else reissues the oldest listed slot with recycled set.
//   A despawn event (action 1) frees slot_index and removes it from the list.
//   Result channel: one result word per command, shown for exactly one cycle
//   with done high, in the cycle after the command is taken (throughput one
//   word per cycle). The receiver cannot stall; done is
//   a strobe only.
//   Configuration channel: cfg_ready is always high; a word on cfg_data is
//   written into slots_in_use when cfg_valid is high. Write it only while idle.
//   Timing: the critical path is set by two ripple chains of POOL_SIZE
//   cells, the free-slot search over the slot cells and the match chain of
//   the order cells.
//   Reset: every slot inactive, the order list empty, slots_in_use = 16.
//   No clearing pass is needed; the block takes commands right after reset.
module pool_slot_allocator_fifo_recycle_unit #(
  parameter int POOL_SIZE = psa_pkg::POOL_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic [psa_pkg::SLOT_W-1:0] slot_index,
  output logic                       done,
  output logic                       granted,
  output logic [psa_pkg::SLOT_W-1:0] granted_slot,
  output logic                       recycled,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [psa_pkg::CFG_W-1:0]  cfg_data
);
  import psa_pkg::*;

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  logic [CFG_W-1:0] slots_in_use;

  logic             accept;
  logic             despawn_ok;
  logic [IDX_W-1:0] target;
  slot_cmd_t        slot_cmd;
  ord_cmd_t         ord_cmd;
  logic             grant_fresh;
  logic             recycle;

  logic [POOL_SIZE-1:0] eligible;
  logic [POOL_SIZE-1:0] slot_active;
  logic [POOL_SIZE:0]   take_chain;
  logic [IDX_W-1:0]     idx_chain [POOL_SIZE+1];

  logic [POOL_SIZE-1:0] ord_valid;
  logic [IDX_W-1:0]     ord_value [POOL_SIZE];
  logic [POOL_SIZE:0]   match_chain;

  // One command word per cycle; configuration is always taken.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Slots-in-use register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slots_in_use <= cfg_data;
    end
  end

  // Decode of the command word.
  assign despawn_ok  = int'(slot_index) < POOL_SIZE;
  assign target      = IDX_W'(slot_index);
  assign grant_fresh = accept && action == ACT_SPAWN && take_chain[POOL_SIZE];
  assign recycle     = accept && action == ACT_SPAWN && !take_chain[POOL_SIZE] &&
                       ord_valid[0];

  assign slot_cmd.spawn   = accept && action == ACT_SPAWN;
  assign slot_cmd.despawn = accept && action == ACT_DESPAWN && despawn_ok;
  assign slot_cmd.recycle = recycle;

  assign ord_cmd.append = grant_fresh;
  assign ord_cmd.remove = slot_cmd.despawn;
  assign ord_cmd.rotate = recycle;

  // Chain ends.
  assign take_chain[0]  = 1'b0;
  assign idx_chain[0]   = '0;
  assign match_chain[0] = 1'b0;

  // Row of slot cells and row of order cells.
  for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
    logic             valid_left;
    logic             valid_right;
    logic [IDX_W-1:0] value_right;

    assign eligible[g] = g < int'(slots_in_use);

    psa_slot_cell #(
      .INDEX (g),
      .IDX_W (IDX_W)
    ) u_slot (
      .clk          (clk),
      .rst          (rst),
      .cmd          (slot_cmd),
      .eligible     (eligible[g]),
      .target       (target),
      .recycle_slot (ord_value[0]),
      .take_in      (take_chain[g]),
      .idx_in       (idx_chain[g]),
      .take_out     (take_chain[g+1]),
      .idx_out      (idx_chain[g+1]),
      .active       (slot_active[g])
    );

    if (g == 0) begin : g_head
      assign valid_left = 1'b1;
    end else begin : g_body
      assign valid_left = ord_valid[g-1];
    end

    if (g == POOL_SIZE - 1) begin : g_tail
      assign valid_right = 1'b0;
      assign value_right = '0;
    end else begin : g_inner
      assign valid_right = ord_valid[g+1];
      assign value_right = ord_value[g+1];
    end

    psa_order_cell #(
      .IDX_W (IDX_W)
    ) u_order (
      .clk         (clk),
      .rst         (rst),
      .cmd         (ord_cmd),
      .new_value   (idx_chain[POOL_SIZE]),
      .target      (target),
      .head_value  (ord_value[0]),
      .valid_left  (valid_left),
      .match_in    (match_chain[g]),
      .valid_right (valid_right),
      .value_right (value_right),
      .match_out   (match_chain[g+1]),
      .valid       (ord_valid[g]),
      .value       (ord_value[g])
    );
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Result word; a despawn or an empty grant reports zeros.
  always_ff @(posedge clk) begin
    granted  <= grant_fresh || recycle;
    recycled <= recycle;
    priority if (grant_fresh) begin
      granted_slot <= SLOT_W'(idx_chain[POOL_SIZE]);
    end else if (recycle) begin
      granted_slot <= SLOT_W'(ord_value[0]);
    end else begin
      granted_slot <= '0;
    end
  end

  // A recycle is always reported as a grant.
  a_recycle_granted: assert property (@(posedge clk) disable iff (rst)
    done && recycled |-> granted)
    else $error("recycle reported without a grant");

  // A despawn event never grants a slot.
  a_despawn_no_grant: assert property (@(posedge clk) disable iff (rst)
    accept && action == ACT_DESPAWN |=> done && !granted && granted_slot == '0)
    else $error("despawn produced a grant");

  // Filled order cells form an unbroken run from the head.
  a_list_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((ord_valid >> 1) & ~ord_valid) == '0)
    else $error("gap in the spawn-order list");

  // The number of active slots equals the number of listed entries.
  a_active_listed: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_active) == $countones(ord_valid))
    else $error("active slots and listed entries disagree");

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the pool slot allocator with oldest-first recycling.
// Depends on psa_pkg and pool_slot_allocator_fifo_recycle_unit from the RTL.
// Predicts each result word in a local allocator and compares it field by field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 3;

  typedef struct {
    logic              act;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct {
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic              recycled;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              action = ACT_SPAWN;
  logic [SLOT_W-1:0] slot_index = '0;
  logic              done;
  logic              granted;
  logic [SLOT_W-1:0] granted_slot;
  logic              recycled;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Commands waiting to be issued and result words waiting to be seen.
  cmd_t   pending_cmds[$];
  grant_t expected_grants[$];

  // Local copy of the allocator state.
  logic [POOL_SIZE_DEF-1:0] pool_active = '0;
  logic [SLOT_W-1:0]        age_list[$];
  logic [CFG_W-1:0]         pool_limit = SLOTS_RESET;

  int errors = 0;
  int cfg_writes = 0;
  int n_cmds = 0, n_fresh = 0, n_recycles = 0, n_empty = 0, n_despawns = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  logic quiet = 1'b0;

  pool_slot_allocator_fifo_recycle_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .slot_index   (slot_index),
    .done         (done),
    .granted      (granted),
    .granted_slot (granted_slot),
    .recycled     (recycled),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Applies one command to the local allocator and returns the word it should produce.
  function automatic grant_t alloc_step(cmd_t c);
    grant_t r;
    int lim;
    logic [SLOT_W-1:0] oldest;
    r = '{1'b0, '0, 1'b0};
    if (c.act == ACT_DESPAWN) begin
      pool_active[c.slot] = 1'b0;
      for (int k = age_list.size() - 1; k >= 0; k--) begin
        if (age_list[k] == c.slot) age_list.delete(k);
      end
      n_despawns++;
    end else begin
      lim = (pool_limit > POOL_SIZE_DEF) ? POOL_SIZE_DEF : int'(pool_limit);
      for (int k = 0; k < lim; k++) begin
        if (!r.granted && !pool_active[k]) begin
          pool_active[k] = 1'b1;
          age_list.push_back(SLOT_W'(k));
          r.granted = 1'b1;
          r.slot = SLOT_W'(k);
        end
      end
      if (r.granted) begin
        n_fresh++;
      end else if (age_list.size() > 0) begin
        // Every usable slot is taken: reissue the oldest one.
        oldest = age_list.pop_front();
        age_list.push_back(oldest);
        pool_active[oldest] = 1'b1;
        r = '{1'b1, oldest, 1'b1};
        n_recycles++;
      end else begin
        n_empty++;
      end
    end
    return r;
  endfunction

  // Driver: issues queued commands, with a random pause after each word outside quiet stretches.
  always @(posedge clk) begin
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && busy) begin
      // Hold the current word until it is taken.
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() > 0) begin
      c = pending_cmds.pop_front();
      action <= c.act;
      slot_index <= c.slot;
      start <= 1'b1;
      if ($urandom_range(0, 31) == 0) quiet <= ~quiet;
      gap_left <= quiet ? 0 : $urandom_range(0, 15);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks result words, predicts accepted commands, tracks writes.
  always @(posedge clk) begin
    grant_t e;
    cmd_t c;
    if (!rst) begin
      if (done) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result word granted=%0d slot=%0d recycled=%0d",
                   $time, granted, granted_slot, recycled);
          errors++;
        end else begin
          e = expected_grants.pop_front();
          if (granted !== e.granted) begin
            $display("%0t: granted expected %0d actual %0d", $time, e.granted, granted);
            errors++;
          end
          if (granted_slot !== e.slot) begin
            $display("%0t: granted_slot expected %0d actual %0d",
                     $time, e.slot, granted_slot);
            errors++;
          end
          if (recycled !== e.recycled) begin
            $display("%0t: recycled expected %0d actual %0d", $time, e.recycled, recycled);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        c = '{action, slot_index};
        expected_grants.push_back(alloc_step(c));
        n_cmds++;
      end
      if (cfg_valid && cfg_ready) begin
        pool_limit = cfg_data;
        cfg_writes++;
      end
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d result words outstanding.",
                 expected_grants.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_cmd(logic act, logic [SLOT_W-1:0] slot);
    cmd_t c;
    c = '{act, slot};
    pending_cmds.push_back(c);
  endtask

  // Waits until every command is taken and every result word has been seen.
  task automatic await_idle();
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_grants.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pool_limit(logic [CFG_W-1:0] value);
    int seen;
    @(posedge clk);
    seen = cfg_writes;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    wait (cfg_writes != seen);
    cfg_valid <= 1'b0;
  endtask

  // Random mix of spawns and despawns; despawns mostly hit usable slots.
  task automatic random_phase(int count);
    int spawn_pct;
    int lim;
    spawn_pct = $urandom_range(30, 75);
    lim = (pool_limit > POOL_SIZE_DEF) ? POOL_SIZE_DEF : int'(pool_limit);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < spawn_pct)
        push_cmd(ACT_SPAWN, SLOT_W'($urandom));
      else if (lim > 0 && $urandom_range(0, 3) != 0)
        push_cmd(ACT_DESPAWN, SLOT_W'($urandom_range(0, lim - 1)));
      else
        push_cmd(ACT_DESPAWN, SLOT_W'($urandom));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] limits[$];
    limits = '{5'd1, 5'd31, 5'd17, 5'd4, 5'd16, 5'd0, 5'd8, 5'd2, 5'd23, 5'd15, 5'd9,
               5'd3};
    limits.push_back(CFG_W'($urandom_range(0, 31)));
    limits.push_back(CFG_W'($urandom_range(0, 31)));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole pool, recycle, then free and reuse a few slots.
    for (int k = 0; k < POOL_SIZE_DEF; k++) push_cmd(ACT_SPAWN, (k % 2) ? '1 : '0);
    push_cmd(ACT_SPAWN, '0);
    push_cmd(ACT_DESPAWN, 4'd3);
    push_cmd(ACT_DESPAWN, 4'd3);
    push_cmd(ACT_DESPAWN, 4'd15);
    push_cmd(ACT_SPAWN, '0);
    push_cmd(ACT_SPAWN, '1);
    push_cmd(ACT_SPAWN, '0);
    push_cmd(ACT_DESPAWN, 4'd0);
    push_cmd(ACT_SPAWN, '0);
    await_idle();

    // No usable slots: recycle while the list is non-empty, then nothing to grant.
    set_pool_limit(5'd0);
    push_cmd(ACT_SPAWN, '0);
    for (int k = 0; k < POOL_SIZE_DEF; k++) push_cmd(ACT_DESPAWN, SLOT_W'(k));
    push_cmd(ACT_SPAWN, '0);
    push_cmd(ACT_SPAWN, '1);
    random_phase(40);
    await_idle();

    foreach (limits[i]) begin
      set_pool_limit(limits[i]);
      random_phase(115);
      await_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d commands: %0d fresh grants, %0d recycles, %0d empty spawns, %0d despawns.",
             n_cmds, n_fresh, n_recycles, n_empty, n_despawns);
    $display("Slot limit was written %0d times, including zero, one, sixteen and 31.",
             cfg_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
